[rtl/core/gmma_pkg.sv]
package gmma_pkg;

    localparam logic [1:0] REQ_READ   = 2'd0;
    localparam logic [1:0] REQ_WRITE  = 2'd1;
    localparam logic [1:0] REQ_ADD    = 2'd2;
    localparam logic [1:0] REQ_REMOVE = 2'd3;

    localparam logic [1:0] KIND_RAM  = 2'd0;
    localparam logic [1:0] KIND_ROM  = 2'd1;
    localparam logic [1:0] KIND_MMIO = 2'd2;
    // spare code, handled as mmio
    localparam logic [1:0] KIND_RSVD = 2'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_UNMAPPED  = 3'd1;
    localparam logic [2:0] ST_MMIO      = 3'd2;
    localparam logic [2:0] ST_ROM_WRITE = 3'd3;
    localparam logic [2:0] ST_BAD_SIZE  = 3'd4;
    localparam logic [2:0] ST_PAST_END  = 3'd5;
    localparam logic [2:0] ST_NO_ROOM   = 3'd6;
    localparam logic [2:0] ST_NOT_FOUND = 3'd7;

    // operands of the shared subtract and compare unit
    typedef struct packed {
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] c;
    } t_alu_req;

    typedef struct packed {
        logic [63:0] d;
        logic        lt;
    } t_alu_rsp;

endpackage

[rtl/core/guest_memory_map_access_core.sv]
// Guest physical memory map: up to NREG regions (RAM, ROM, MMIO) over one byte-wide
// backing store of STORE_BYTES. One item at a time; o_in_stall stays high until the
// result is in the output register. A read or write scans every slot through the
// shared subtract/compare unit, then decides and, for a store access, checks the
// region end, then writes the bytes one by one or reads each byte with a capture
// step (single store port with registered read), then hands over the result. A remove
// scans the slots, commits and hands over. An add checks for a free slot and, for a
// RAM or ROM region, the store window, which it zeroes a byte at a time through the
// store port before it commits. No clearing pass is needed after reset.
module guest_memory_map_access_core #(
    parameter int NREG        = 8,
    parameter int STORE_BYTES = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_req_type,
    input  logic [63:0] i_address,
    input  logic [3:0]  i_access_size,
    input  logic [63:0] i_write_data,
    input  logic [63:0] i_region_size,
    input  logic [1:0]  i_region_kind,
    input  logic [15:0] i_storage_start,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_status,
    output logic [63:0] o_read_data,
    output logic [2:0]  o_region_slot,
    output logic [63:0] o_region_offset
);

    localparam int SW = (NREG > 1) ? $clog2(NREG) : 1;
    localparam int AW = $clog2(STORE_BYTES);
    localparam int PW = (AW > 16) ? AW : 16;
    localparam logic [63:0] STORE_LEN  = 64'(STORE_BYTES);
    localparam logic [63:0] STORE_LIM  = 64'(STORE_BYTES) + 64'd1;
    localparam logic [SW-1:0] LAST_IDX = SW'(NREG - 1);

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_DECIDE, S_END, S_MEM, S_CAP,
        S_ACHK1, S_ACHK2, S_CLEAR, S_ACOMMIT, S_REM_DONE, S_OUT
    } t_state;

    t_state r_state, n_state;

    // slot table
    logic [NREG-1:0] r_valid;
    logic [63:0]     r_base    [NREG];
    logic [63:0]     r_length  [NREG];
    logic [1:0]      r_kind    [NREG];
    logic [15:0]     r_storage [NREG];
    logic [SW-1:0]   r_age     [NREG];

    // latched item
    logic [1:0]  r_req;
    logic [63:0] r_addr;
    logic [3:0]  r_size;
    logic [63:0] r_wdata;
    logic [63:0] r_len;
    logic [1:0]  r_rkind;
    logic [15:0] r_start;

    // work registers
    logic [SW-1:0] r_idx;
    logic          r_found;
    logic [SW-1:0] r_slot;
    logic [SW-1:0] r_best_age;
    logic [63:0]   r_off;
    logic [AW-1:0] r_ptr;
    logic [AW:0]   r_cnt;
    logic [2:0]    r_b;
    logic [2:0]    r_res_st;
    logic [63:0]   r_res_data;
    logic [2:0]    r_res_slot;
    logic [63:0]   r_res_off;

    gmma_pkg::t_alu_req alu_req;
    gmma_pkg::t_alu_rsp alu_rsp;

    logic          st_we;
    logic [7:0]    st_wdata;
    logic [7:0]    st_rdata;
    logic          any_free;
    logic [SW-1:0] free_idx;
    logic          size_ok;
    logic          is_storage;
    logic          last_byte;
    logic [PW-1:0] ptr_sum;

    gmma_alu u_alu (
        .i_req (alu_req),
        .o_rsp (alu_rsp)
    );

    gmma_store #(
        .DEPTH (STORE_BYTES),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_addr  (r_ptr),
        .i_wdata (st_wdata),
        .o_rdata (st_rdata)
    );

    always_comb begin
        alu_req = '0;
        case (r_state)
            S_SCAN: begin
                alu_req.a = r_addr;
                alu_req.b = r_base[r_idx];
                alu_req.c = (r_req == gmma_pkg::REQ_REMOVE) ? 64'd1 : r_length[r_idx];
            end
            S_END: begin
                alu_req.a = r_length[r_slot];
                alu_req.b = r_off;
                alu_req.c = 64'(r_size);
            end
            S_ACHK1: begin
                alu_req.a = r_len;
                alu_req.c = STORE_LIM;
            end
            S_ACHK2: begin
                alu_req.a = STORE_LEN;
                alu_req.b = r_len;
                alu_req.c = 64'(r_start);
            end
            default: alu_req = '0;
        endcase
    end

    always_comb begin
        any_free = 1'b0;
        free_idx = '0;
        for (int i = NREG - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                any_free = 1'b1;
                free_idx = SW'(i);
            end
        end
    end

    assign size_ok    = r_size inside {4'd1, 4'd2, 4'd4, 4'd8};
    assign is_storage = (r_kind[r_slot] == gmma_pkg::KIND_RAM)
                     || (r_kind[r_slot] == gmma_pkg::KIND_ROM);
    assign last_byte  = ({1'b0, r_b} + 4'd1) == r_size;
    assign ptr_sum    = PW'(r_storage[r_slot]) + PW'(r_off[AW-1:0]);
    assign st_we      = (r_state == S_CLEAR)
                     || (r_state == S_MEM && r_req == gmma_pkg::REQ_WRITE);
    assign st_wdata   = (r_state == S_CLEAR) ? 8'd0 : r_wdata[{r_b, 3'b000} +: 8];
    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_req_type == gmma_pkg::REQ_ADD) n_state = S_ACHK1;
                    else                                 n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_idx == LAST_IDX) begin
                    n_state = (r_req == gmma_pkg::REQ_REMOVE) ? S_REM_DONE : S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (r_found && is_storage && size_ok
                    && !(r_req == gmma_pkg::REQ_WRITE
                         && r_kind[r_slot] == gmma_pkg::KIND_ROM)) begin
                    n_state = S_END;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_END:   n_state = alu_rsp.lt ? S_OUT : S_MEM;
            S_MEM: begin
                if (r_req == gmma_pkg::REQ_READ) n_state = S_CAP;
                else if (last_byte)              n_state = S_OUT;
            end
            S_CAP:   n_state = last_byte ? S_OUT : S_MEM;
            S_ACHK1: begin
                if (!any_free)                                      n_state = S_OUT;
                else if (r_rkind != gmma_pkg::KIND_RAM
                         && r_rkind != gmma_pkg::KIND_ROM)          n_state = S_ACOMMIT;
                else if (!alu_rsp.lt)                               n_state = S_OUT;
                else                                                n_state = S_ACHK2;
            end
            S_ACHK2: begin
                if (alu_rsp.lt)        n_state = S_OUT;
                else if (r_len == '0)  n_state = S_ACOMMIT;
                else                   n_state = S_CLEAR;
            end
            S_CLEAR:    n_state = (r_cnt == (AW+1)'(1)) ? S_ACOMMIT : S_CLEAR;
            S_ACOMMIT:  n_state = S_OUT;
            S_REM_DONE: n_state = S_OUT;
            S_OUT:      n_state = (!o_out_valid || !i_out_stall) ? S_IDLE : S_OUT;
            default:    n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            o_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_OUT && (!o_out_valid || !i_out_stall)) begin
                o_out_valid <= 1'b1;
            end else if (o_out_valid && !i_out_stall) begin
                o_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    r_req      <= i_req_type;
                    r_addr     <= i_address;
                    r_size     <= i_access_size;
                    r_wdata    <= i_write_data;
                    r_len      <= i_region_size;
                    r_rkind    <= i_region_kind;
                    r_start    <= i_storage_start;
                    r_idx      <= '0;
                    r_found    <= 1'b0;
                    r_slot     <= '0;
                    r_off      <= '0;
                    r_res_st   <= gmma_pkg::ST_OK;
                    r_res_data <= '0;
                    r_res_slot <= '0;
                    r_res_off  <= '0;
                end
                S_SCAN: begin
                    // newest covering (or base matching) slot wins
                    if (r_valid[r_idx] && alu_rsp.lt
                        && (!r_found || r_age[r_idx] < r_best_age)) begin
                        r_found    <= 1'b1;
                        r_slot     <= r_idx;
                        r_best_age <= r_age[r_idx];
                        r_off      <= alu_rsp.d;
                    end
                    r_idx <= r_idx + SW'(1);
                end
                S_DECIDE: begin
                    if (!r_found) begin
                        r_res_st   <= gmma_pkg::ST_UNMAPPED;
                        r_res_data <= (r_req == gmma_pkg::REQ_READ) ? '1 : '0;
                    end else begin
                        r_res_slot <= 3'(r_slot);
                        r_res_off  <= r_off;
                        if (!is_storage) begin
                            r_res_st <= gmma_pkg::ST_MMIO;
                        end else if (r_req == gmma_pkg::REQ_WRITE
                                     && r_kind[r_slot] == gmma_pkg::KIND_ROM) begin
                            r_res_st <= gmma_pkg::ST_ROM_WRITE;
                        end else if (!size_ok) begin
                            r_res_st <= gmma_pkg::ST_BAD_SIZE;
                        end
                    end
                end
                S_END: begin
                    if (alu_rsp.lt) begin
                        r_res_st <= gmma_pkg::ST_PAST_END;
                    end
                    // window checked at add, so no wrap inside the store
                    r_ptr <= ptr_sum[AW-1:0];
                    r_b   <= '0;
                end
                S_MEM: begin
                    if (r_req == gmma_pkg::REQ_WRITE) begin
                        r_ptr <= r_ptr + AW'(1);
                        r_b   <= r_b + 3'd1;
                    end
                end
                S_CAP: begin
                    r_res_data[{r_b, 3'b000} +: 8] <= st_rdata;
                    r_ptr <= r_ptr + AW'(1);
                    r_b   <= r_b + 3'd1;
                end
                S_ACHK1: begin
                    if (!any_free || ((r_rkind == gmma_pkg::KIND_RAM
                                       || r_rkind == gmma_pkg::KIND_ROM) && !alu_rsp.lt)) begin
                        r_res_st <= gmma_pkg::ST_NO_ROOM;
                    end
                    if (r_rkind != gmma_pkg::KIND_RAM && r_rkind != gmma_pkg::KIND_ROM) begin
                        r_start <= '0;
                    end
                end
                S_ACHK2: begin
                    if (alu_rsp.lt) begin
                        r_res_st <= gmma_pkg::ST_NO_ROOM;
                    end
                    r_ptr <= AW'(PW'(r_start));
                    r_cnt <= r_len[AW:0];
                end
                S_CLEAR: begin
                    r_ptr <= r_ptr + AW'(1);
                    r_cnt <= r_cnt - (AW+1)'(1);
                end
                S_ACOMMIT: begin
                    for (int i = 0; i < NREG; i++) begin
                        if (r_valid[i]) r_age[i] <= r_age[i] + SW'(1);
                    end
                    r_valid[free_idx]   <= 1'b1;
                    r_base[free_idx]    <= r_addr;
                    r_length[free_idx]  <= r_len;
                    r_kind[free_idx]    <= r_rkind;
                    r_storage[free_idx] <= r_start;
                    r_age[free_idx]     <= '0;
                    r_res_slot          <= 3'(free_idx);
                end
                S_REM_DONE: begin
                    if (!r_found) begin
                        r_res_st <= gmma_pkg::ST_NOT_FOUND;
                    end else begin
                        for (int i = 0; i < NREG; i++) begin
                            if (r_valid[i] && r_age[i] > r_best_age) begin
                                r_age[i] <= r_age[i] - SW'(1);
                            end
                        end
                        r_valid[r_slot] <= 1'b0;
                        r_age[r_slot]   <= '0;
                        r_res_slot      <= 3'(r_slot);
                    end
                end
                S_OUT: begin
                    if (!o_out_valid || !i_out_stall) begin
                        o_status        <= r_res_st;
                        o_read_data     <= r_res_data;
                        o_region_slot   <= r_res_slot;
                        o_region_offset <= r_res_off;
                    end
                end
                default: ;
            endcase
        end
    end

    // a result only appears from the hand-over state
    a_out_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_OUT))
        else $error("result appeared outside hand-over");

    // store traffic only for a region that was found
    a_mem_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MEM || r_state == S_CAP) |-> r_found)
        else $error("store access without a matched region");

    // clear loop never entered with nothing to clear
    a_clear_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> (r_cnt != '0))
        else $error("clear count underflow");

    // the table changes only on add or remove commit
    a_table_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_state == S_ACOMMIT || r_state == S_REM_DONE) |=> $stable(r_valid))
        else $error("slot valid bits changed outside commit");

endmodule

[rtl/core/gmma_alu.sv]
module gmma_alu (
    input  gmma_pkg::t_alu_req i_req,
    output gmma_pkg::t_alu_rsp o_rsp
);

    logic [63:0] diff;

    // d = a - b (mod 2^64), lt = d < c
    assign diff     = i_req.a - i_req.b;
    assign o_rsp.d  = diff;
    assign o_rsp.lt = diff < i_req.c;

endmodule

[rtl/core/gmma_store.sv]
module gmma_store #(
    parameter int DEPTH = 65536,
    parameter int AW    = 16
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_addr,
    input  logic [7:0]    i_wdata,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule
